// ===== src/alc_pkg.sv =====
package alc_pkg;

   // Field widths
   localparam int unsigned CNT_W      = 8;
   localparam int unsigned TEMP_W     = 9;
   localparam int unsigned THR_W      = 8;
   localparam int unsigned RPM_W      = 16;
   localparam int unsigned RPM_HUN_W  = 10;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 9;
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 8;

   // Minimum speed register counts in tens of rpm
   localparam logic [3:0] RPM_TENS_SCALE = 4'd10;

   // Build option defaults
   localparam bit FAN_ENABLED_DEF         = 1'b1;
   localparam bit REQUEST_ACTIVE_HIGH_DEF = 1'b1;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_AFTER_START_DELAY      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_COMPRESSOR_ON_DELAY    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_THROTTLE_CUT           = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_THROTTLE_RELEASE_TICKS = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_RPM_TENS           = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_RPM_HUNDREDS       = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_RPM_RELEASE_TICKS      = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_COOLANT_CUT_TEMP       = 3'd7;

   // One control tick
   typedef struct packed {
      logic [RPM_HUN_W-1:0]    engine_rpm_hundreds;
      logic [RPM_W-1:0]        engine_rpm;
      logic [THR_W-1:0]        throttle_pos;
      logic signed [TEMP_W-1:0] coolant_temp;
      logic                    request_pin;
      logic                    engine_running;
   } tick_type;

   // One result
   typedef struct packed {
      logic coolant_locked;
      logic throttle_locked;
      logic rpm_locked;
      logic turning_on;
      logic request_active;
      logic fan_on;
      logic compressor_on;
   } result_type;

endpackage

// ===== src/aircon_lockout_controller_top.sv =====
// Air-conditioning lockout controller. Each req_ beat is one control tick and
// gives exactly one rsp_ beat holding the compressor, fan, request, turning-on
// and lockout bits after that tick. The block takes one beat per clock cycle
// while rsp_tready stays high. A beat's result is registered: the beat passes
// the input register, then the single tick stage of counters and compares,
// then the result register, which drives rsp_. A stalled rsp_ holds the result
// and drops req_tready once the input register is also full. The coolant
// lockout has a 2-degree hysteresis band; the throttle and speed lockouts
// release after their stand-down tick counts. Write the csr_ registers only
// while no beat is in flight.
module aircon_lockout_controller_top #(
   parameter bit FAN_ENABLED         = alc_pkg::FAN_ENABLED_DEF,
   parameter bit REQUEST_ACTIVE_HIGH = alc_pkg::REQUEST_ACTIVE_HIGH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // bits: engine_running[0], request_pin[1], coolant_temp[10:2],
   // throttle_pos[18:11], engine_rpm[34:19], engine_rpm_hundreds[44:35], zero pad
   input  logic [alc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // bits: compressor_on[0], fan_on[1], request_active[2], turning_on[3],
   // rpm_locked[4], throttle_locked[5], coolant_locked[6], zero pad [7]
   output logic [alc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [alc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [alc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned CW = alc_pkg::CNT_W;

   // Configuration registers
   logic [CW-1:0] after_start_delay_ff;
   logic [CW-1:0] compressor_on_delay_ff;
   logic [CW-1:0] throttle_cut_ff;
   logic [CW-1:0] throttle_release_ticks_ff;
   logic [CW-1:0] min_rpm_tens_ff;
   logic [CW-1:0] max_rpm_hundreds_ff;
   logic [CW-1:0] rpm_release_ticks_ff;
   logic signed [alc_pkg::TEMP_W-1:0] coolant_cut_temp_ff;

   // Control state
   logic [CW-1:0] start_wait_count_ff,       start_wait_count_in;
   logic          start_wait_done_ff,        start_wait_done_in;
   logic [CW-1:0] compressor_wait_count_ff,  compressor_wait_count_in;
   logic [CW-1:0] throttle_release_count_ff, throttle_release_count_in;
   logic [CW-1:0] rpm_release_count_ff,      rpm_release_count_in;
   logic          throttle_lock_ff,          throttle_lock_in;
   logic          rpm_lock_ff,               rpm_lock_in;
   logic          coolant_lock_ff,           coolant_lock_in;

   // Pipeline registers
   logic                 in_valid_ff;
   alc_pkg::tick_type    in_tick_ff;
   logic                 out_valid_ff;
   alc_pkg::result_type  out_res_ff, out_res_in;

   logic advance;
   logic signed [alc_pkg::TEMP_W:0] temp_ext;
   logic signed [alc_pkg::TEMP_W:0] cut_minus_one;
   logic [11:0] min_rpm;
   logic        rpm_out_of_range;
   logic        req_act;
   logic        turn_on;

   // Move a tick into the result register when the result slot is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_res_ff};

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         after_start_delay_ff      <= '0;
         compressor_on_delay_ff    <= '0;
         throttle_cut_ff           <= '0;
         throttle_release_ticks_ff <= '0;
         min_rpm_tens_ff           <= '0;
         max_rpm_hundreds_ff       <= '0;
         rpm_release_ticks_ff      <= '0;
         coolant_cut_temp_ff       <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            alc_pkg::REG_AFTER_START_DELAY:      after_start_delay_ff      <= csr_wdata[CW-1:0];
            alc_pkg::REG_COMPRESSOR_ON_DELAY:    compressor_on_delay_ff    <= csr_wdata[CW-1:0];
            alc_pkg::REG_THROTTLE_CUT:           throttle_cut_ff           <= csr_wdata[CW-1:0];
            alc_pkg::REG_THROTTLE_RELEASE_TICKS: throttle_release_ticks_ff <= csr_wdata[CW-1:0];
            alc_pkg::REG_MIN_RPM_TENS:           min_rpm_tens_ff           <= csr_wdata[CW-1:0];
            alc_pkg::REG_MAX_RPM_HUNDREDS:       max_rpm_hundreds_ff       <= csr_wdata[CW-1:0];
            alc_pkg::REG_RPM_RELEASE_TICKS:      rpm_release_ticks_ff      <= csr_wdata[CW-1:0];
            alc_pkg::REG_COOLANT_CUT_TEMP:       coolant_cut_temp_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture an input beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_tick_ff <= alc_pkg::tick_type'(req_tdata[$bits(alc_pkg::tick_type)-1:0]);
      end
   end

   // Tick logic: next state and result for the tick in the input register
   always_comb begin
      temp_ext      = {in_tick_ff.coolant_temp[alc_pkg::TEMP_W-1], in_tick_ff.coolant_temp};
      cut_minus_one = {coolant_cut_temp_ff[alc_pkg::TEMP_W-1], coolant_cut_temp_ff} - 10'sd1;
      min_rpm       = 12'(min_rpm_tens_ff) * 12'(alc_pkg::RPM_TENS_SCALE);

      // post-start delay
      start_wait_count_in = start_wait_count_ff;
      start_wait_done_in  = start_wait_done_ff;
      if (in_tick_ff.engine_running) begin
         if (start_wait_count_ff >= after_start_delay_ff) begin
            start_wait_done_in = 1'b1;
         end else begin
            start_wait_count_in = start_wait_count_ff + 1'b1;
         end
      end else begin
         start_wait_count_in = '0;
         start_wait_done_in  = 1'b0;
      end

      // coolant lockout, hold inside the dead band
      coolant_lock_in = coolant_lock_ff;
      if (in_tick_ff.coolant_temp > coolant_cut_temp_ff) begin
         coolant_lock_in = 1'b1;
      end else if (temp_ext < cut_minus_one) begin
         coolant_lock_in = 1'b0;
      end

      // throttle lockout with stand-down count
      throttle_lock_in          = throttle_lock_ff;
      throttle_release_count_in = throttle_release_count_ff;
      if (in_tick_ff.throttle_pos > throttle_cut_ff) begin
         throttle_lock_in          = 1'b1;
         throttle_release_count_in = '0;
      end else if (throttle_lock_ff) begin
         if (throttle_release_count_ff >= throttle_release_ticks_ff) begin
            throttle_lock_in = 1'b0;
         end else begin
            throttle_release_count_in = throttle_release_count_ff + 1'b1;
         end
      end else begin
         throttle_release_count_in = '0;
      end

      // speed lockout; the count runs while in range
      rpm_out_of_range = (in_tick_ff.engine_rpm < {4'd0, min_rpm}) ||
                         (in_tick_ff.engine_rpm_hundreds > {2'd0, max_rpm_hundreds_ff});
      rpm_lock_in          = rpm_lock_ff;
      rpm_release_count_in = rpm_release_count_ff;
      if (rpm_out_of_range) begin
         rpm_lock_in          = 1'b1;
         rpm_release_count_in = '0;
      end else if (rpm_release_count_ff >= rpm_release_ticks_ff) begin
         rpm_lock_in = 1'b0;
      end else begin
         rpm_release_count_in = rpm_release_count_ff + 1'b1;
      end

      // request decision
      req_act = REQUEST_ACTIVE_HIGH ? in_tick_ff.request_pin : !in_tick_ff.request_pin;
      turn_on = req_act && start_wait_done_in && !throttle_lock_in &&
                !rpm_lock_in && !coolant_lock_in;

      compressor_wait_count_in  = compressor_wait_count_ff;
      out_res_in.compressor_on  = out_res_ff.compressor_on;
      out_res_in.fan_on         = 1'b0;
      if (turn_on) begin
         out_res_in.fan_on = FAN_ENABLED;
         if (compressor_wait_count_ff >= compressor_on_delay_ff) begin
            out_res_in.compressor_on = 1'b1;
         end else begin
            compressor_wait_count_in = compressor_wait_count_ff + 1'b1;
         end
      end else begin
         out_res_in.compressor_on = 1'b0;
         compressor_wait_count_in = '0;
      end

      out_res_in.request_active  = req_act;
      out_res_in.turning_on      = turn_on;
      out_res_in.rpm_locked      = rpm_lock_in;
      out_res_in.throttle_locked = throttle_lock_in;
      out_res_in.coolant_locked  = coolant_lock_in;
   end

   // Advance state and load the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         start_wait_count_ff       <= '0;
         start_wait_done_ff        <= 1'b0;
         compressor_wait_count_ff  <= '0;
         throttle_release_count_ff <= '0;
         rpm_release_count_ff      <= '0;
         throttle_lock_ff          <= 1'b0;
         rpm_lock_ff               <= 1'b0;
         coolant_lock_ff           <= 1'b0;
         out_valid_ff              <= 1'b0;
         out_res_ff                <= '0;
      end else begin
         if (advance) begin
            start_wait_count_ff       <= start_wait_count_in;
            start_wait_done_ff        <= start_wait_done_in;
            compressor_wait_count_ff  <= compressor_wait_count_in;
            throttle_release_count_ff <= throttle_release_count_in;
            rpm_release_count_ff      <= rpm_release_count_in;
            throttle_lock_ff          <= throttle_lock_in;
            rpm_lock_ff               <= rpm_lock_in;
            coolant_lock_ff           <= coolant_lock_in;
            out_res_ff                <= out_res_in;
            out_valid_ff              <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Compressor runs only on an accepted request
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.compressor_on |-> out_res_ff.turning_on)
      else $error("compressor on without turning_on");

   // Fan follows turning_on
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.fan_on |-> out_res_ff.turning_on)
      else $error("fan on without turning_on");

   // No request is accepted through an active lockout
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.turning_on |->
         !(out_res_ff.rpm_locked || out_res_ff.throttle_locked || out_res_ff.coolant_locked))
      else $error("turning_on during lockout");

   // A stalled tick stays in the input register
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_tick_ff))
      else $error("stalled tick lost");

   // Speed and coolant lockout flags mirror the latest result
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_res_ff.rpm_locked == rpm_lock_ff &&
                       out_res_ff.coolant_locked == coolant_lock_ff)
      else $error("result out of step with lockout state");

endmodule
